### design/fcfl_pkg.sv
// ----------------------------------------------------------------------------
// fcfl_pkg: shared types and constants for the chunk free-list allocator
// Operation, status and register codes, sizes and the command/status
// structs between controller and datapath.
// ----------------------------------------------------------------------------
package fcfl_pkg;

    localparam int POOL_CHUNKS = 256;
    localparam int IDX_W       = $clog2(POOL_CHUNKS);
    localparam int LIVE_MAX    = (POOL_CHUNKS < 256) ? POOL_CHUNKS : 256;

    localparam int SIZE_W  = 16;
    localparam int COUNT_W = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [SIZE_W-1:0]  PTR_BYTES         = 16'd8;
    localparam logic [SIZE_W-1:0]  CHUNK_SIZE_RESET  = 16'd64;
    localparam logic [COUNT_W-1:0] CHUNKS_USE_RESET  = 9'd256;

    typedef enum logic [1:0] {
        FN_ALLOC   = 2'd0,
        FN_RELEASE = 2'd1,
        FN_CLEAN   = 2'd2,
        FN_NOP     = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_EMPTY       = 2'd1,
        ST_TOO_LARGE   = 2'd2,
        ST_BAD_RELEASE = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHUNK_SIZE    = 2'd0,
        CFG_CHUNKS_IN_USE = 2'd1
    } t_cfg_reg;

    typedef struct packed {
        logic load;     // latch the accepted request
        logic commit;   // apply the operation and fill the output register
    } t_dp_cmd;

    typedef struct packed {
        logic out_slot_free;  // output register empty or draining this cycle
    } t_dp_stat;

    // Clamp the configured chunk count to 1 .. LIVE_MAX.
    function automatic logic [COUNT_W-1:0] live_count(input logic [COUNT_W-1:0] n);
        logic [COUNT_W-1:0] res;
        res = n;
        if (n == '0) begin
            res = COUNT_W'(1);
        end else if (n > COUNT_W'(LIVE_MAX)) begin
            res = COUNT_W'(LIVE_MAX);
        end
        return res;
    endfunction

endpackage

### design/fixed_chunk_free_list_allocator.sv
// ----------------------------------------------------------------------------
// fixed_chunk_free_list_allocator: pool allocator with a LIFO free list
// Hands out and takes back equal-size chunks by index; the free chunks form
// a linked list kept in a table of next links.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------
//  request  | i_in_valid / o_in_ready   | i_func, i_request_size, i_release_index
//  result   | o_out_valid / i_out_ready | o_granted_index, o_status, o_free_left
//  config   | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  Every request is latched, then the link of the current head is read
//  from the link RAM (registered read), then it commits. Clean clears
//  one valid bit per table entry at once instead of sweeping.
//  Reset (synchronous, active low) leaves the list as after a clean; no
//  clearing pass follows. A full output register holds the commit until
//  the result is taken, and the request side stays closed until the commit.
//  The config port is always ready.
//
module fixed_chunk_free_list_allocator
    import fcfl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_func,
    input  logic [SIZE_W-1:0]     i_request_size,
    input  logic [IDX_W-1:0]      i_release_index,
    // result
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [IDX_W-1:0]      o_granted_index,
    output logic [1:0]            o_status,
    output logic [COUNT_W-1:0]    o_free_left,
    // configuration
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // registers take every write transfer immediately
    assign o_cfg_ready = 1'b1;

    fcfl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    fcfl_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_func          (i_func),
        .i_request_size  (i_request_size),
        .i_release_index (i_release_index),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_granted_index (o_granted_index),
        .o_status        (o_status),
        .o_free_left     (o_free_left)
    );

`ifndef SYNTHESIS
    // one request in flight: an accepted transfer closes the request side
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while another is in flight");

    // a commit never overwrites a result that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.commit |-> (!o_out_valid || i_out_ready))
        else $error("result overwritten before transfer");

    // only a granted allocation carries a chunk index
    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_granted_index == '0))
        else $error("nonzero index on a failed request");

    // free count never exceeds the pool
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_free_left <= COUNT_W'(LIVE_MAX)))
        else $error("free count above pool size");
`endif

endmodule

### design/fcfl_ram.sv
// ----------------------------------------------------------------------------
// fcfl_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fcfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/fcfl_ctrl.sv
// ----------------------------------------------------------------------------
// fcfl_ctrl: request sequencer
// Accept one request, wait in S_EXEC for the head link read, then commit
// once the output register can take the result.
// ----------------------------------------------------------------------------
module fcfl_ctrl
    import fcfl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                // hold until the result has a place to go
                if (i_stat.out_slot_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### design/fcfl_dp.sv
// ----------------------------------------------------------------------------
// fcfl_dp: allocator datapath
// Configuration registers, head and free count, link table with valid
// bits, and the output register.
// ----------------------------------------------------------------------------
module fcfl_dp
    import fcfl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic [1:0]            i_func,
    input  logic [SIZE_W-1:0]     i_request_size,
    input  logic [IDX_W-1:0]      i_release_index,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [IDX_W-1:0]      o_granted_index,
    output logic [1:0]            o_status,
    output logic [COUNT_W-1:0]    o_free_left
);

    // configuration
    logic [SIZE_W-1:0]  r_chunk_size;
    logic [COUNT_W-1:0] r_chunks_in_use;

    // latched request
    t_func              r_func;
    logic [SIZE_W-1:0]  r_req;
    logic [IDX_W-1:0]   r_rel;

    // list state
    logic [IDX_W-1:0]       r_head, n_head;
    logic [COUNT_W-1:0]     r_free, n_free;
    logic [POOL_CHUNKS-1:0] r_vld, n_vld;
    logic                   r_head_vld;

    // output register
    logic               r_out_valid, n_out_valid;
    logic [IDX_W-1:0]   r_granted, n_granted;
    t_status            r_status, n_status;
    logic [COUNT_W-1:0] r_free_left;

    logic [IDX_W-1:0]   ram_rdata;
    logic [IDX_W-1:0]   head_link;
    logic               link_we;
    logic [SIZE_W-1:0]  eff_size;
    logic [COUNT_W-1:0] live;

    fcfl_ram #(
        .WIDTH (IDX_W),
        .DEPTH (POOL_CHUNKS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (r_rel),
        .i_wdata (r_head),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    assign o_stat.out_slot_free = !r_out_valid || i_out_ready;

    // an entry never written since clean links to its successor
    assign head_link = r_head_vld ? ram_rdata : r_head + IDX_W'(1);
    assign eff_size  = (r_chunk_size < PTR_BYTES) ? PTR_BYTES : r_chunk_size;
    assign live      = live_count(r_chunks_in_use);

    always_comb begin
        n_head      = r_head;
        n_free      = r_free;
        n_vld       = r_vld;
        n_granted   = '0;
        n_status    = ST_OK;
        link_we     = 1'b0;
        n_out_valid = i_out_ready ? 1'b0 : r_out_valid;
        if (i_cmd.commit) begin
            n_out_valid = 1'b1;
            case (r_func)
                FN_ALLOC: begin
                    if (r_req > eff_size) begin
                        n_status = ST_TOO_LARGE;
                    end else if (r_free == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_granted = r_head;
                        n_head    = head_link;
                        n_free    = r_free - COUNT_W'(1);
                    end
                end
                FN_RELEASE: begin
                    if ({1'b0, r_rel} >= live || r_free >= live) begin
                        n_status = ST_BAD_RELEASE;
                    end else begin
                        link_we      = 1'b1;
                        n_vld[r_rel] = 1'b1;
                        n_head       = r_rel;
                        n_free       = r_free + COUNT_W'(1);
                    end
                end
                FN_CLEAN: begin
                    n_vld  = '0;
                    n_head = '0;
                    n_free = live;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_size    <= CHUNK_SIZE_RESET;
            r_chunks_in_use <= CHUNKS_USE_RESET;
            r_head          <= '0;
            r_free          <= live_count(CHUNKS_USE_RESET);
            r_vld           <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_CHUNK_SIZE:    r_chunk_size    <= i_cfg_data;
                    CFG_CHUNKS_IN_USE: r_chunks_in_use <= i_cfg_data[COUNT_W-1:0];
                    default: begin
                    end
                endcase
            end
            r_head      <= n_head;
            r_free      <= n_free;
            r_vld       <= n_vld;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_head_vld <= r_vld[r_head];
        if (i_cmd.load) begin
            r_func <= t_func'(i_func);
            r_req  <= i_request_size;
            r_rel  <= i_release_index;
        end
        if (i_cmd.commit) begin
            r_granted   <= n_granted;
            r_status    <= n_status;
            r_free_left <= n_free;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_granted_index = r_granted;
    assign o_status        = r_status;
    assign o_free_left     = r_free_left;

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for fixed_chunk_free_list_allocator
// Drives alloc, release, clean and no-op requests with random gaps, stalls
// the result channel at random, and checks every result against a local
// copy of the free list kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module testbench;
    import fcfl_pkg::*;

    typedef struct {
        logic [IDX_W-1:0]   granted;
        t_status            status;
        logic [COUNT_W-1:0] free_left;
    } t_pool_result;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the link table, head and free count, and queues the
    // result that each accepted request must produce.
    // ------------------------------------------------------------------------
    class pool_scoreboard;
        logic [IDX_W-1:0]   link_tbl [POOL_CHUNKS];
        logic [IDX_W-1:0]   head;
        logic [COUNT_W-1:0] free_cnt;
        logic [SIZE_W-1:0]  chunk_bytes;
        logic [COUNT_W-1:0] chunks_cfg;
        t_pool_result       result_q [$];
        int                 errors;

        function new();
            errors      = 0;
            chunk_bytes = 16'd64;
            chunks_cfg  = 9'd256;
            rebuild();
        endfunction

        // Chunk count that clean places in the list; zero acts as one.
        function int live_chunks();
            int n;
            n = chunks_cfg;
            if (n < 1) n = 1;
            if (n > LIVE_MAX) n = LIVE_MAX;
            return n;
        endfunction

        function int chunk_limit();
            return (chunk_bytes < PTR_BYTES) ? int'(PTR_BYTES) : int'(chunk_bytes);
        endfunction

        function void rebuild();
            for (int i = 0; i < POOL_CHUNKS; i++) begin
                link_tbl[i] = IDX_W'(i + 1);
            end
            head     = '0;
            free_cnt = COUNT_W'(live_chunks());
        endfunction

        // A register write never rebuilds the list.
        function void write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_CHUNK_SIZE:    chunk_bytes = data;
                CFG_CHUNKS_IN_USE: chunks_cfg  = data[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        function int outstanding();
            return result_q.size();
        endfunction

        // Apply one accepted request and queue the result it must give.
        function t_pool_result note_request(t_func f, logic [SIZE_W-1:0] size,
                                            logic [IDX_W-1:0] rel);
            t_pool_result res;
            int           n;
            res.granted = '0;
            res.status  = ST_OK;
            case (f)
                FN_ALLOC: begin
                    // size check wins over the empty check
                    if (int'(size) > chunk_limit()) begin
                        res.status = ST_TOO_LARGE;
                    end else if (free_cnt == 0) begin
                        res.status = ST_EMPTY;
                    end else begin
                        res.granted = head;
                        head        = link_tbl[head];
                        free_cnt    = free_cnt - COUNT_W'(1);
                    end
                end
                FN_RELEASE: begin
                    n = live_chunks();
                    if (int'(rel) >= n || int'(free_cnt) >= n) begin
                        res.status = ST_BAD_RELEASE;
                    end else begin
                        link_tbl[rel] = head;
                        head          = rel;
                        free_cnt      = free_cnt + COUNT_W'(1);
                    end
                end
                FN_CLEAN: rebuild();
                default: ;
            endcase
            res.free_left = free_cnt;
            result_q.push_back(res);
            return res;
        endfunction

        function void check_result(logic [IDX_W-1:0] granted, logic [1:0] status,
                                   logic [COUNT_W-1:0] free_left);
            t_pool_result exp;
            if (result_q.size() == 0) begin
                $display("%0t: unexpected result granted_index %0d status %0d free_left %0d",
                         $time, granted, status, free_left);
                errors++;
                return;
            end
            exp = result_q.pop_front();
            if (granted !== exp.granted) begin
                $display("%0t: granted_index expected %0d actual %0d",
                         $time, exp.granted, granted);
                errors++;
            end
            if (status !== exp.status) begin
                $display("%0t: status expected %0d actual %0d", $time, exp.status, status);
                errors++;
            end
            if (free_left !== exp.free_left) begin
                $display("%0t: free_left expected %0d actual %0d",
                         $time, exp.free_left, free_left);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT connections
    // ------------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [1:0]            i_func;
    logic [SIZE_W-1:0]     i_request_size;
    logic [IDX_W-1:0]      i_release_index;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [IDX_W-1:0]      o_granted_index;
    logic [1:0]            o_status;
    logic [COUNT_W-1:0]    o_free_left;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    fixed_chunk_free_list_allocator u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_func          (i_func),
        .i_request_size  (i_request_size),
        .i_release_index (i_release_index),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_granted_index (o_granted_index),
        .o_status        (o_status),
        .o_free_left     (o_free_left),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    pool_scoreboard   sb = new();
    logic [IDX_W-1:0] held_q [$];   // chunks handed out and not yet returned
    logic             calm_in  = 1'b0;  // no gaps between requests
    logic             calm_out = 1'b0;  // no stalls on the result channel

    // 4 ns clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #2_000_000;
        $display("testbench: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Request driver. Enter and leave at a falling edge; valid stays high on
    // exit so that a back-to-back request never drops it within one step.
    // ------------------------------------------------------------------------
    task automatic send_request(input t_func f, input logic [SIZE_W-1:0] size,
                                input logic [IDX_W-1:0] rel);
        t_pool_result exp;
        int           gap;
        gap = calm_in ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_func          <= f;
        i_request_size  <= size;
        i_release_index <= rel;
        // wait for the transfer; ready is read before this edge's updates land
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        exp = sb.note_request(f, size, rel);
        // track granted chunks so releases can return real allocations
        if (f == FN_ALLOC && exp.status == ST_OK) held_q.push_back(exp.granted);
        if (f == FN_CLEAN) held_q.delete();
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every queued result has been taken.
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (sb.outstanding() != 0);
    endtask

    // Write one register; call only when the block is idle.
    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] bytes,
                             input logic [CFG_DATA_W-1:0] count);
        settle();
        write_reg(CFG_CHUNK_SIZE, bytes);
        write_reg(CFG_CHUNKS_IN_USE, count);
    endtask

    // One random request; mostly well-formed allocs and returns of held chunks.
    task automatic random_request();
        int               pick;
        int               pos;
        logic [IDX_W-1:0] rel;
        logic [SIZE_W-1:0] size;
        pick = $urandom_range(0, 99);
        size = SIZE_W'($urandom);
        rel  = IDX_W'($urandom);
        if (pick < 45) begin
            if ($urandom_range(0, 99) < 80) begin
                size = SIZE_W'($urandom_range(0, sb.chunk_limit()));
            end
            send_request(FN_ALLOC, size, rel);
        end else if (pick < 88) begin
            if (held_q.size() > 0 && $urandom_range(0, 99) < 70) begin
                pos = $urandom_range(0, held_q.size() - 1);
                rel = held_q[pos];
                held_q.delete(pos);
            end else if ($urandom_range(0, 99) < 85) begin
                rel = IDX_W'($urandom_range(0, sb.live_chunks() - 1));
            end
            send_request(FN_RELEASE, size, rel);
        end else if (pick < 94) begin
            send_request(FN_CLEAN, size, rel);
        end else begin
            send_request(FN_NOP, size, rel);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stall before each transfer, then check it.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        i_out_ready = 1'b0;
        @(negedge i_clk);
        forever begin
            stall = calm_out ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(i_rst_n === 1'b1 && o_out_valid === 1'b1));
            sb.check_result(o_granted_index, o_status, o_free_left);
            @(negedge i_clk);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [CFG_DATA_W-1:0] bytes;
        logic [CFG_DATA_W-1:0] count;
        int                    sel;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_func          = FN_NOP;
        i_request_size  = '0;
        i_release_index = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = CFG_CHUNK_SIZE;
        i_cfg_data      = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset state: 64-byte chunks, full list of 256.
        send_request(FN_ALLOC, 16'd0, 8'd0);
        send_request(FN_ALLOC, 16'd64, 8'd0);       // exactly the chunk size
        send_request(FN_ALLOC, 16'd65, 8'd0);       // one byte too many
        send_request(FN_ALLOC, 16'hFFFF, 8'hFF);
        send_request(FN_RELEASE, 16'hFFFF, 8'd255); // top index
        send_request(FN_RELEASE, 16'd0, 8'd0);
        send_request(FN_RELEASE, 16'd0, 8'd1);      // list already full
        send_request(FN_NOP, 16'hA5A5, 8'h5A);
        send_request(FN_ALLOC, 16'd8, 8'd0);
        send_request(FN_CLEAN, 16'h5A5A, 8'hA5);

        // Zero size acts as the pointer size; zero count acts as one chunk.
        configure(16'd0, 16'd0);
        send_request(FN_CLEAN, 16'd0, 8'd0);
        send_request(FN_ALLOC, 16'd8, 8'd0);
        send_request(FN_ALLOC, 16'd9, 8'd0);        // too large wins over empty
        send_request(FN_ALLOC, 16'd0, 8'd0);        // pool empty
        send_request(FN_RELEASE, 16'd0, 8'd1);      // index past the live count
        send_request(FN_RELEASE, 16'd0, 8'd0);
        send_request(FN_RELEASE, 16'd0, 8'd0);      // full again

        // Largest size, count above the pool clamps to 256; list not rebuilt.
        configure(16'hFFFF, 16'h01FF);
        send_request(FN_ALLOC, 16'hFFFF, 8'd0);
        send_request(FN_CLEAN, 16'd0, 8'd0);
        send_request(FN_ALLOC, 16'hFFFF, 8'd0);
        send_request(FN_RELEASE, 16'd0, 8'd200);    // double release goes unseen
        send_request(FN_ALLOC, 16'd1, 8'd0);
        send_request(FN_ALLOC, 16'd1, 8'd0);

        // Random phases, each with its own settings and idle behavior.
        for (int phase = 0; phase < 8; phase++) begin
            sel = $urandom_range(0, 3);
            case (sel)
                0:       bytes = CFG_DATA_W'($urandom_range(0, 7));
                1:       bytes = 16'd8;
                2:       bytes = 16'hFFFF;
                default: bytes = CFG_DATA_W'($urandom);
            endcase
            sel = $urandom_range(0, 5);
            case (sel)
                0:       count = CFG_DATA_W'($urandom_range(0, 2));
                1:       count = 16'd256;
                2:       count = CFG_DATA_W'($urandom);
                3:       count = CFG_DATA_W'($urandom_range(1, 511));
                default: count = CFG_DATA_W'($urandom_range(2, 16));
            endcase
            configure(bytes, count);
            calm_in  = (phase == 2) || ($urandom_range(0, 3) == 0);
            calm_out = (phase == 2) || ($urandom_range(0, 3) == 0);
            // usually start from a rebuilt list; sometimes keep the stale one
            if ($urandom_range(0, 3) != 0) begin
                send_request(FN_CLEAN, SIZE_W'($urandom), IDX_W'($urandom));
            end
            repeat (200) random_request();
        end

        // Drain and let any stray result show up.
        settle();
        repeat (16) @(negedge i_clk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

### files.f
design/fcfl_pkg.sv
design/fcfl_ram.sv
design/fcfl_ctrl.sv
design/fcfl_dp.sv
design/fixed_chunk_free_list_allocator.sv
verif/testbench.sv
